// ===== rtl/chm_pkg.sv =====
// Shared constants for the chained hash map.
package chm_pkg;
  localparam int DefBuckets = 256;
  localparam int DefNodes = 1024;
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;
endpackage

// ===== rtl/chm_mod.sv =====
// Bit-serial remainder of a 64-bit magnitude by the bucket count.
module chm_mod import chm_pkg::*; #(
  parameter int BW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   mag,
  input  logic [BW-1:0] divisor,
  output logic          done,
  output logic [BW-1:0] rem
);
  logic [63:0] sh;
  logic [BW:0] r;
  logic [6:0] cnt;
  logic run;
  logic [BW+1:0] trial;

  assign trial = {r, sh[63]};
  assign rem = r[BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && !start && cnt == 7'd63;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        sh <= mag;
        r <= '0;
      end else if (run) begin
        // shift one dividend bit in, subtract when it fits
        if (trial >= {2'b0, divisor}) begin
          r <= (BW + 1)'(trial - {2'b0, divisor});
        end else begin
          r <= trial[BW:0];
        end
        sh <= {sh[62:0], 1'b0};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run <= 1'b0;
        end
      end
    end
  end
endmodule

// ===== rtl/chm_ctrl.sv =====
// Chain-walk sequencer with the bucket head and node memories.
module chm_ctrl import chm_pkg::*; #(
  parameter int BUCKETS = DefBuckets,
  parameter int NODES = DefNodes,
  parameter int BW = $clog2(BUCKETS + 1),
  parameter int BA = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
  parameter int NA = (NODES > 1) ? $clog2(NODES) : 1,
  parameter int NW = $clog2(NODES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          op,
  input  logic [63:0]   key,
  input  logic [63:0]   value,
  input  logic [BW-1:0] active,
  output logic          busy,
  output logic          result_valid,
  output logic          found,
  output logic [63:0]   found_value,
  output logic          status
);
  localparam logic [2:0] S_IDLE = 3'd0, S_CLEAR = 3'd1, S_MOD = 3'd2, S_HEAD = 3'd3,
    S_NODE = 3'd4, S_CHECK = 3'd5, S_WRITE = 3'd6;
  localparam logic [NW-1:0] EMPTY = NW'(NODES);

  logic [2:0] state;
  logic [BA:0] clr;
  logic op_r;
  logic [63:0] key_r, value_r;
  logic mod_start, mod_done;
  logic [BW-1:0] rem;
  logic [BA-1:0] bucket;
  logic [NW-1:0] cur, head;
  logic [NW-1:0] used;
  logic [NW:0] steps;
  logic hit;
  logic [NW-1:0] node_addr;

  logic [NW-1:0] heads [BUCKETS];
  logic [63:0] nkeys [NODES];
  logic [63:0] nvals [NODES];
  logic [NW-1:0] nlinks [NODES];
  logic [NW-1:0] head_q, link_q;
  logic [63:0] nkey_q, nval_q;

  chm_mod #(.BW(BW)) u_mod (
    .clk, .rst, .start(mod_start),
    .mag(key_r[63] ? 64'(-key_r) : key_r),
    .divisor(active), .done(mod_done), .rem
  );

  assign busy = state != S_IDLE;
  assign mod_start = state == S_MOD && !mod_done && steps == '0;
  // forward the chain head into the node read on the first step
  assign node_addr = (state == S_NODE && steps == '0) ? head_q : cur;

  always_ff @(posedge clk) begin
    head_q <= heads[bucket];
    nkey_q <= nkeys[node_addr[NA-1:0]];
    nval_q <= nvals[node_addr[NA-1:0]];
    link_q <= nlinks[node_addr[NA-1:0]];
    if (state == S_CLEAR) heads[clr[BA-1:0]] <= EMPTY;
    if (state == S_WRITE && op_r == OP_PUT) begin
      if (hit) begin
        nvals[cur[NA-1:0]] <= value_r;
      end else if (used < EMPTY) begin
        nkeys[used[NA-1:0]] <= key_r;
        nvals[used[NA-1:0]] <= value_r;
        nlinks[used[NA-1:0]] <= head;
        heads[bucket] <= used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      used <= '0;
      result_valid <= 1'b0;
      steps <= '0;
    end else begin
      result_valid <= state == S_WRITE;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (BA + 1)'(BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          op_r <= op;
          key_r <= key;
          value_r <= value;
          steps <= '0;
          state <= S_MOD;
        end
        S_MOD: begin
          if (mod_done) begin
            bucket <= BA'(rem);
            steps <= '0;
            state <= S_HEAD;
          end else begin
            steps <= (NW + 1)'(1);
          end
        end
        S_HEAD: state <= S_NODE;
        S_NODE: begin
          // head read landed on first entry into this state
          if (steps == '0) begin
            head <= head_q;
            cur <= head_q;
            hit <= 1'b0;
            if (head_q >= EMPTY) state <= S_WRITE;
            else state <= S_CHECK;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // node read now valid for cur
          if (nkey_q == key_r) begin
            hit <= 1'b1;
            state <= S_WRITE;
          end else if (link_q >= EMPTY || steps == (NW + 1)'(NODES - 1)) begin
            state <= S_WRITE;
          end else begin
            cur <= link_q;
            steps <= steps + 1'b1;
            state <= S_NODE;
          end
        end
        S_WRITE: begin
          found <= hit;
          found_value <= (op_r == OP_LOOKUP && hit) ? nval_q : 64'd0;
          status <= (op_r == OP_PUT && !hit && used >= EMPTY) ? STATUS_FULL : STATUS_DONE;
          if (op_r == OP_PUT && !hit && used < EMPTY) used <= used + 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/chained_hash_map.sv =====
// One request at a time: the 64-step bit-serial remainder and the chain walk finish
// before the next request is accepted. Busy is high from accept until the strobe.
// After reset a clearing pass empties every bucket head (busy high).
// Results appear for one cycle on result_valid; the receiver cannot stall.
module chained_hash_map import chm_pkg::*; #(
  parameter int BUCKETS = DefBuckets,
  parameter int NODES = DefNodes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [63:0] key,
  input  logic [63:0] value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  bucket_count,
  output logic        result_valid,
  output logic        found,
  output logic [63:0] found_value,
  output logic        status
);
  localparam int BW = $clog2(BUCKETS + 1);
  logic [8:0] bc;
  logic [BW-1:0] active;

  // hold config writes off while a request is in flight
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) bc <= 9'd256;
    else if (cfg_valid && cfg_ready) bc <= bucket_count;
  end

  always_comb begin
    if (bc == 9'd0) active = BW'(1);
    else if (32'(bc) > BUCKETS) active = BW'(BUCKETS);
    else active = BW'(bc);
  end

  chm_ctrl #(.BUCKETS(BUCKETS), .NODES(NODES)) u_ctrl (
    .clk, .rst, .start, .op, .key, .value, .active, .busy,
    .result_valid, .found, .found_value, .status
  );
endmodule

// ===== rtl/chm_checker.sv =====
// Port-level checks for the chained hash map.
module chm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic        found,
  input logic [63:0] found_value,
  input logic        status
);
  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("no busy after accept");
  a_res_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("busy during result");
  a_fnd_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> !found) else $error("dropped put found");
  a_val_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> found_value == 64'd0) else $error("value on miss");
endmodule

bind chained_hash_map chm_checker u_chk (
  .clk, .rst, .start, .busy, .result_valid, .found, .found_value, .status
);
